// ===== rtl/core/isotp_receive_reassembly_assert.svh =====
// Assertion macros used by the reassembly controller
`ifndef ISOTP_RECEIVE_REASSEMBLY_ASSERT_SVH
`define ISOTP_RECEIVE_REASSEMBLY_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst
`define ISOTP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define ISOTP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/isotp_pkg.sv =====
// Shared types and codes of the transport-frame reassembly block
package isotp_pkg;

  localparam int BUF_BYTES_DEF = 32;
  localparam int MSG_LEN_W     = 6;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;

  localparam logic [15:0] GAP_TIMEOUT_RST = 16'd1000;
  localparam logic [7:0]  SERVICE_RST     = 8'h27;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SERVICE     = 1'b1;

  // Frame types, high nibble of the control byte
  localparam logic [3:0] FT_SINGLE = 4'h0;
  localparam logic [3:0] FT_FIRST  = 4'h1;
  localparam logic [3:0] FT_CONSEC = 4'h2;
  localparam logic [3:0] FT_FLOW   = 4'h3;

  // Result kinds
  localparam logic [1:0] KIND_FLOW_CTRL = 2'd0;
  localparam logic [1:0] KIND_NEG_RESP  = 2'd1;
  localparam logic [1:0] KIND_MSG_BYTE  = 2'd2;

  // Negative response reasons
  localparam logic [1:0] NRC_BAD_LENGTH  = 2'd0;
  localparam logic [1:0] NRC_SEQUENCE    = 2'd1;
  localparam logic [1:0] NRC_TIMEOUT     = 2'd2;
  localparam logic [1:0] NRC_UNSUPPORTED = 2'd3;

  // Source of the service id echoed in a negative response
  localparam logic [1:0] SVC_STORED = 2'd0;
  localparam logic [1:0] SVC_CONFIG = 2'd1;
  localparam logic [1:0] SVC_BYTE1  = 2'd2;
  localparam logic [1:0] SVC_BYTE2  = 2'd3;

  typedef struct packed {
    logic [7:0][7:0] bytes;
    logic [31:0]     now;
  } frame_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [7:0]           service;
    logic [1:0]           reason;
    logic [7:0]           data;
    logic [MSG_LEN_W-1:0] length;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic       capture;
    logic       close;
    logic       open_ff;
    logic       advance_cf;
    logic       wr_step;
    logic       drain_start;
    logic       rd_issue;
    logic       drain_next;
    logic       out_load;
    logic [1:0] out_kind;
    logic [1:0] svc_sel;
    logic [1:0] reason;
  } cmd_t;

  typedef struct packed {
    logic       timed_out;
    logic [3:0] ftype;
    logic       len_bad;
    logic       seq_ok;
    logic       active;
    logic       wr_more;
    logic       ff_mode;
    logic       complete;
    logic       svc_match;
    logic       drain_last;
    logic       out_free;
  } sts_t;

endpackage

// ===== rtl/core/isotp_ifs.sv =====
// Valid/ready channel interfaces for frames in and results out
interface isotp_frame_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_byte_0;
  logic [7:0]  frame_byte_1;
  logic [7:0]  frame_byte_2;
  logic [7:0]  frame_byte_3;
  logic [7:0]  frame_byte_4;
  logic [7:0]  frame_byte_5;
  logic [7:0]  frame_byte_6;
  logic [7:0]  frame_byte_7;
  logic [31:0] now_ms;

  modport source (
    output valid, frame_byte_0, frame_byte_1, frame_byte_2, frame_byte_3,
           frame_byte_4, frame_byte_5, frame_byte_6, frame_byte_7, now_ms,
    input  ready
  );
  modport sink (
    input  valid, frame_byte_0, frame_byte_1, frame_byte_2, frame_byte_3,
           frame_byte_4, frame_byte_5, frame_byte_6, frame_byte_7, now_ms,
    output ready
  );
endinterface

interface isotp_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] nrc_service;
  logic [1:0] nrc_reason;
  logic [7:0] msg_byte;
  logic [5:0] msg_length;
  logic       last;

  modport source (
    output valid, result_kind, nrc_service, nrc_reason, msg_byte, msg_length, last,
    input  ready
  );
  modport sink (
    input  valid, result_kind, nrc_service, nrc_reason, msg_byte, msg_length, last,
    output ready
  );
endinterface

// ===== rtl/core/isotp_dp.sv =====
// Reassembly datapath: frame capture, session registers, message store, result register
module isotp_dp #(
  parameter int BUF_BYTES = isotp_pkg::BUF_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [isotp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [isotp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  isotp_pkg::frame_t                  frame,
  input  isotp_pkg::cmd_t                    cmd,
  output isotp_pkg::sts_t                    sts,
  input  logic                               result_ready,
  output logic                               result_valid,
  output isotp_pkg::result_t                 result
);

  localparam int LEN_W = $clog2(BUF_BYTES + 1);
  localparam int AW    = $clog2(BUF_BYTES);
  localparam int ML_W  = isotp_pkg::MSG_LEN_W;

  // Configuration
  logic [15:0] gap_timeout;
  logic [7:0]  acc_svc;

  // Captured frame
  logic [7:0][7:0] fb;
  logic [31:0]     fnow;

  // Session
  logic             active;
  logic [LEN_W-1:0] exp_len;
  logic [LEN_W-1:0] brx;
  logic [3:0]       nseq;
  logic [31:0]      last_time;
  logic [7:0]       svc_id;
  logic             ff_mode;
  logic [3:0]       sidx;

  // Drain
  logic [LEN_W-1:0] dlen;
  logic [AW-1:0]    didx;
  logic [7:0]       rdata;

  logic [7:0] mem [BUF_BYTES];

  logic [31:0]        gap;
  logic [LEN_W+ML_W-1:0] dlen_ext;
  logic [7:0]         nrc_svc;
  logic               is_neg;
  logic               is_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_timeout <= isotp_pkg::GAP_TIMEOUT_RST;
      acc_svc     <= isotp_pkg::SERVICE_RST;
    end else if (cfg_we) begin
      if (cfg_index == isotp_pkg::REG_GAP_TIMEOUT) gap_timeout <= cfg_data;
      if (cfg_index == isotp_pkg::REG_SERVICE)     acc_svc     <= cfg_data[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      fb   <= frame.bytes;
      fnow <= frame.now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      exp_len   <= '0;
      brx       <= '0;
      nseq      <= '0;
      last_time <= '0;
      ff_mode   <= 1'b0;
      sidx      <= '0;
    end else begin
      priority if (cmd.open_ff) begin
        active    <= 1'b1;
        exp_len   <= LEN_W'(fb[1]);
        brx       <= '0;
        nseq      <= 4'd1;
        last_time <= fnow;
        ff_mode   <= 1'b1;
        sidx      <= 4'd2;
      end else if (cmd.close) begin
        active    <= 1'b0;
        exp_len   <= '0;
        brx       <= '0;
        nseq      <= '0;
        last_time <= '0;
      end else if (cmd.advance_cf) begin
        nseq      <= nseq + 4'd1;
        last_time <= fnow;
        ff_mode   <= 1'b0;
        sidx      <= 4'd1;
      end else if (cmd.wr_step) begin
        brx  <= brx + LEN_W'(1);
        sidx <= sidx + 4'd1;
      end else begin
        // hold the session
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.open_ff) svc_id <= fb[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      didx <= '0;
      dlen <= '0;
    end else if (cmd.drain_start) begin
      didx <= '0;
      dlen <= exp_len;
    end else if (cmd.drain_next) begin
      didx <= didx + AW'(1);
    end
  end

  // Message store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_step) mem[brx[AW-1:0]] <= fb[sidx[2:0]];
    if (cmd.rd_issue) rdata <= mem[didx];
  end

  always_comb begin
    unique case (cmd.svc_sel)
      isotp_pkg::SVC_STORED: nrc_svc = svc_id;
      isotp_pkg::SVC_CONFIG: nrc_svc = acc_svc;
      isotp_pkg::SVC_BYTE1:  nrc_svc = fb[1];
      default:               nrc_svc = fb[2];
    endcase
  end

  assign dlen_ext = {{ML_W{1'b0}}, dlen};
  assign is_neg   = cmd.out_kind == isotp_pkg::KIND_NEG_RESP;
  assign is_byte  = cmd.out_kind == isotp_pkg::KIND_MSG_BYTE;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.kind    <= cmd.out_kind;
      result.service <= is_neg ? nrc_svc : 8'd0;
      result.reason  <= is_neg ? cmd.reason : 2'd0;
      result.data    <= is_byte ? rdata : 8'd0;
      result.length  <= is_byte ? dlen_ext[ML_W-1:0] : {ML_W{1'b0}};
      result.last    <= is_byte ? sts.drain_last : 1'b1;
    end
  end

  assign gap = fnow - last_time;

  always_comb begin
    sts.timed_out  = active && (gap > {16'b0, gap_timeout});
    sts.ftype      = fb[0][7:4];
    sts.len_bad    = (fb[1] == 8'd0) || (9'({1'b0, fb[1]}) > 9'(BUF_BYTES));
    sts.seq_ok     = fb[0][3:0] == nseq;
    sts.active     = active;
    sts.wr_more    = !sidx[3] &&
                     (ff_mode || ((brx < exp_len) && (brx < LEN_W'(BUF_BYTES))));
    sts.ff_mode    = ff_mode;
    sts.complete   = brx >= exp_len;
    sts.svc_match  = svc_id == acc_svc;
    sts.drain_last = didx == AW'(dlen - LEN_W'(1));
    sts.out_free   = !result_valid || result_ready;
  end

endmodule

// ===== rtl/core/isotp_ctrl.sv =====
// Reassembly controller: sequences capture, checks, store writes and message drain
`include "isotp_receive_reassembly_assert.svh"

module isotp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             frame_valid,
  output logic             frame_ready,
  input  isotp_pkg::sts_t  sts,
  output isotp_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_LD    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign frame_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (frame_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        // Every result-producing path waits for the result register
        priority if (sts.timed_out) begin
          if (sts.out_free) begin
            cmd.close    = 1'b1;
            cmd.out_load = 1'b1;
            cmd.out_kind = isotp_pkg::KIND_NEG_RESP;
            cmd.svc_sel  = isotp_pkg::SVC_STORED;
            cmd.reason   = isotp_pkg::NRC_TIMEOUT;
            state_next   = S_IDLE;
          end
        end else if (sts.ftype == isotp_pkg::FT_FIRST) begin
          if (sts.out_free) begin
            cmd.close    = 1'b1;
            cmd.out_load = 1'b1;
            if (sts.len_bad) begin
              cmd.out_kind = isotp_pkg::KIND_NEG_RESP;
              cmd.svc_sel  = isotp_pkg::SVC_BYTE2;
              cmd.reason   = isotp_pkg::NRC_BAD_LENGTH;
              state_next   = S_IDLE;
            end else begin
              cmd.open_ff  = 1'b1;
              cmd.out_kind = isotp_pkg::KIND_FLOW_CTRL;
              state_next   = S_WRITE;
            end
          end
        end else if (sts.ftype == isotp_pkg::FT_CONSEC) begin
          if (sts.active && sts.seq_ok) begin
            cmd.advance_cf = 1'b1;
            state_next     = S_WRITE;
          end else if (sts.out_free) begin
            cmd.close    = sts.active;
            cmd.out_load = 1'b1;
            cmd.out_kind = isotp_pkg::KIND_NEG_RESP;
            cmd.svc_sel  = sts.active ? isotp_pkg::SVC_STORED : isotp_pkg::SVC_CONFIG;
            cmd.reason   = isotp_pkg::NRC_SEQUENCE;
            state_next   = S_IDLE;
          end
        end else if (sts.ftype == isotp_pkg::FT_FLOW) begin
          state_next = S_IDLE;
        end else begin
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = isotp_pkg::KIND_NEG_RESP;
            cmd.svc_sel  = isotp_pkg::SVC_BYTE1;
            cmd.reason   = isotp_pkg::NRC_BAD_LENGTH;
            state_next   = S_IDLE;
          end
        end
      end
      S_WRITE: begin
        if (sts.wr_more) cmd.wr_step = 1'b1;
        else if (sts.ff_mode) state_next = S_IDLE;
        else state_next = S_FIN;
      end
      S_FIN: begin
        priority if (!sts.complete) begin
          state_next = S_IDLE;
        end else if (sts.svc_match) begin
          cmd.drain_start = 1'b1;
          cmd.close       = 1'b1;
          state_next      = S_RD;
        end else begin
          if (sts.out_free) begin
            cmd.close    = 1'b1;
            cmd.out_load = 1'b1;
            cmd.out_kind = isotp_pkg::KIND_NEG_RESP;
            cmd.svc_sel  = isotp_pkg::SVC_STORED;
            cmd.reason   = isotp_pkg::NRC_UNSUPPORTED;
            state_next   = S_IDLE;
          end
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_LD;
      end
      S_LD: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_kind   = isotp_pkg::KIND_MSG_BYTE;
          cmd.drain_next = 1'b1;
          state_next     = sts.drain_last ? S_IDLE : S_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `ISOTP_ASSERT_IMP(a_load_needs_room, cmd.out_load, sts.out_free,
                    "result register overwritten before transfer")
  `ISOTP_ASSERT_NXT(a_drain_reads, cmd.drain_start, state == S_RD,
                    "drain did not start with a store read")
  `ISOTP_ASSERT_NXT(a_byte_loop, (state == S_LD) && sts.out_free,
                    (state == S_RD) || (state == S_IDLE), "drain loop left its path")

endmodule

// ===== rtl/core/isotp_receive_reassembly.sv =====
// Receive-side transport-frame reassembly: one 8-byte frame in, zero or more results out.
// A frame is captured and then judged (timeout by a 32-bit wrapping subtract and compare,
// then frame type). A first frame then writes six of its bytes into the message store, a
// consecutive frame up to seven, one byte per cycle on the store's single write port; the
// controller then leaves the write loop and, for a consecutive frame, makes the completion
// check. A completed message drains byte by byte, each byte through a registered store
// read and then a result register load. Results leave through a registered output; a
// stalled output holds the sequence where the next result would be loaded. A new frame is
// taken once the previous one has been fully handled, even while its last result waits in
// the output register. Configuration is to be written through cfg_we/cfg_index/cfg_data
// while the block is idle; the block itself does not enforce this.
module isotp_receive_reassembly #(
  parameter int MSG_BUF_BYTES = isotp_pkg::BUF_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [isotp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [isotp_pkg::CFG_DATA_W-1:0] cfg_data,
  isotp_frame_if.sink                      frames,
  isotp_result_if.source                   results
);

  isotp_pkg::frame_t  frame;
  isotp_pkg::cmd_t    cmd;
  isotp_pkg::sts_t    sts;
  isotp_pkg::result_t result;
  logic               out_valid;
  logic               in_ready;

  assign frame.bytes = {frames.frame_byte_7, frames.frame_byte_6,
                        frames.frame_byte_5, frames.frame_byte_4,
                        frames.frame_byte_3, frames.frame_byte_2,
                        frames.frame_byte_1, frames.frame_byte_0};
  assign frame.now    = frames.now_ms;
  assign frames.ready = in_ready;

  isotp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frames.valid),
    .frame_ready (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  isotp_dp #(
    .BUF_BYTES (MSG_BUF_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .frame        (frame),
    .cmd          (cmd),
    .sts          (sts),
    .result_ready (results.ready),
    .result_valid (out_valid),
    .result       (result)
  );

  assign results.valid       = out_valid;
  assign results.result_kind = result.kind;
  assign results.nrc_service = result.service;
  assign results.nrc_reason  = result.reason;
  assign results.msg_byte    = result.data;
  assign results.msg_length  = result.length;
  assign results.last        = result.last;

endmodule
